### hdl/retry_backoff_table_top_macros.svh
// ----------------------------------------------------------------------------
// Retry backoff table assertion macros
// Shared concurrent assertion forms for the retry backoff table.
// ----------------------------------------------------------------------------
`ifndef RETRY_BACKOFF_TABLE_TOP_MACROS_SVH
`define RETRY_BACKOFF_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rbt_pkg.sv
// ----------------------------------------------------------------------------
// Retry backoff table package
// Command and status codes, field widths and the word that walks the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rbt_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned LimW   = 8;
  localparam int unsigned BaseW  = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CntW   = 9;
  localparam int unsigned DelayW = 12;

  localparam logic [CntW-1:0]   CountCap = 9'd256;
  localparam logic [DelayW-1:0] DelayCap = 12'd3600;
  // Shift amounts at or above this always exceed the delay cap.
  localparam logic [CntW-1:0]   ShiftMax = 9'd12;

  typedef enum logic [CmdW-1:0] {
    CMD_SET   = 2'd0,
    CMD_INC   = 2'd1,
    CMD_RST   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  // Command word as it travels down the cell chain. The limit and base fields
  // carry the request on entry; the owning cell overwrites them with the job's
  // own: the limit on an increment, reset or query, the base on an increment.
  typedef struct packed {
    cmd_e              cmd;
    logic [KeyW-1:0]   key;
    logic [LimW-1:0]   lim;
    logic [BaseW-1:0]  base;
    logic [CntW-1:0]   cnt;
    logic              found;
    logic              appended;
  } tok_t;

endpackage

`default_nettype wire

### hdl/rbt_if.sv
// ----------------------------------------------------------------------------
// Retry backoff table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbt_req_if;
  import rbt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [KeyW-1:0]   job_key;
  logic [LimW-1:0]   retry_limit;
  logic [BaseW-1:0]  base_delay;

  modport source (output valid, command, job_key, retry_limit, base_delay, input ready);
  modport sink   (input valid, command, job_key, retry_limit, base_delay, output ready);
endinterface

interface rbt_rsp_if;
  import rbt_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatW-1:0]   status;
  logic [CntW-1:0]    retry_count;
  logic [LimW-1:0]    limit_out;
  logic [DelayW-1:0]  delay_seconds;

  modport source (output valid, status, retry_count, limit_out, delay_seconds, input ready);
  modport sink   (input valid, status, retry_count, limit_out, delay_seconds, output ready);
endinterface

`default_nettype wire

### hdl/rbt_cell.sv
// ----------------------------------------------------------------------------
// Retry backoff table cell
// Holds one job slot and passes the command word on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rbt_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned IdxW    = 7,
  parameter int unsigned SlotKeyW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [IdxW-1:0] used_i,
  input  wire logic          tok_vld_i,
  input  wire rbt_pkg::tok_t tok_i,
  output logic               tok_vld_o,
  output rbt_pkg::tok_t      tok_o
);
  import rbt_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic [SlotKeyW-1:0] key_q;
  logic [LimW-1:0]     limit_q;
  logic [BaseW-1:0]    delay_q;
  logic [CntW-1:0]     retries_q;
  logic [CntW-1:0]     retries_d;

  logic  tok_vld_q;
  tok_t  tok_q, tok_d;
  logic  sel, hit, app;
  logic  wr_key, wr_cfg, wr_cnt;

  always_comb begin
    tok_d     = tok_i;
    retries_d = '0;
    wr_key    = 1'b0;
    wr_cfg    = 1'b0;
    wr_cnt    = 1'b0;

    sel = tok_vld_i && !tok_i.found;
    hit = sel && (used_i > MyIdx) && (key_q == tok_i.key[SlotKeyW-1:0]);
    // The first free slot takes a new job when no used slot matched.
    app = sel && (used_i == MyIdx) && (tok_i.cmd == CMD_SET);

    if (hit || app) begin
      tok_d.found    = 1'b1;
      tok_d.appended = app;
      case (tok_i.cmd)
        CMD_SET: begin
          wr_key    = app;
          wr_cfg    = 1'b1;
          wr_cnt    = 1'b1;
          tok_d.cnt = '0;
        end
        CMD_INC: begin
          retries_d  = (retries_q == CountCap) ? retries_q : retries_q + 1'b1;
          wr_cnt     = 1'b1;
          tok_d.cnt  = retries_d;
          tok_d.lim  = limit_q;
          tok_d.base = delay_q;
        end
        CMD_RST: begin
          wr_cnt    = 1'b1;
          tok_d.cnt = '0;
          tok_d.lim = limit_q;
        end
        CMD_QUERY: begin
          tok_d.cnt = retries_q;
          tok_d.lim = limit_q;
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr_key) begin
      key_q <= tok_i.key[SlotKeyW-1:0];
    end
    if (wr_cfg) begin
      limit_q <= tok_i.lim;
      delay_q <= tok_i.base;
    end
    if (wr_cnt) begin
      retries_q <= retries_d;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

`default_nettype wire

### hdl/rbt_backoff.sv
// ----------------------------------------------------------------------------
// Retry backoff table result stage
// Turns the word leaving the chain into status, count, limit and delay.
// ----------------------------------------------------------------------------
`default_nettype none

module rbt_backoff (
  input  wire rbt_pkg::tok_t         tok_i,
  output rbt_pkg::status_e           status_o,
  output logic [rbt_pkg::CntW-1:0]   cnt_o,
  output logic [rbt_pkg::LimW-1:0]   lim_o,
  output logic [rbt_pkg::DelayW-1:0] delay_o
);
  import rbt_pkg::*;

  localparam int unsigned WideW = BaseW + 11;

  logic [CntW-1:0]  sh;
  logic [WideW-1:0] wide;
  logic [DelayW-1:0] delay_calc;

  // Delay is base * 2^(count-1), capped; the count is at least one here.
  always_comb begin
    sh   = tok_i.cnt - 1'b1;
    wide = {{(WideW-BaseW){1'b0}}, tok_i.base} << sh[3:0];
    if (tok_i.base == '0) begin
      delay_calc = '0;
    end else if (sh >= ShiftMax) begin
      delay_calc = DelayCap;
    end else if (wide > WideW'(DelayCap)) begin
      delay_calc = DelayCap;
    end else begin
      delay_calc = wide[DelayW-1:0];
    end
  end

  always_comb begin
    status_o = ST_OK;
    cnt_o    = tok_i.cnt;
    lim_o    = tok_i.lim;
    delay_o  = '0;
    if (!tok_i.found) begin
      status_o = (tok_i.cmd == CMD_SET) ? ST_FULL : ST_NOT_FOUND;
      cnt_o    = '0;
      lim_o    = '0;
    end else begin
      case (tok_i.cmd)
        CMD_INC: begin
          if (tok_i.cnt > {1'b0, tok_i.lim}) begin
            status_o = ST_EXHAUSTED;
          end else begin
            delay_o = delay_calc;
          end
        end
        CMD_SET, CMD_RST, CMD_QUERY: begin
          status_o = ST_OK;
        end
        default: begin
          status_o = ST_OK;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/retry_backoff_table_top.sv
// ----------------------------------------------------------------------------
// Retry backoff table
// Capped exponential backoff bookkeeping for a table of keyed jobs.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells, one job slot each. An accepted
// command word enters the first cell and moves one cell per clock; the cell
// that holds the job key (or, for a set of a new key, the first free cell)
// updates its slot and stamps the word with the job's data. After the last
// cell a result stage forms the response, which is held in an output register
// until the sink takes it. One command is in flight at a time:
// ready returns in the cycle after the response word is taken, so a command
// costs more time the longer the cell chain is, even with an always-ready sink.
// Job slots need no clearing after reset.
`default_nettype none

`include "retry_backoff_table_top_macros.svh"

module retry_backoff_table_top #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BITS    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rbt_req_if.sink   req_i,
  rbt_rsp_if.source rsp_o
);
  import rbt_pkg::*;

  localparam int unsigned IdxW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SlotKeyW = (KEY_BITS < KeyW) ? KEY_BITS : KeyW;
  localparam logic [IdxW-1:0] DepthVal = IdxW'(TABLE_DEPTH);

  logic            busy_q;
  logic [IdxW-1:0] used_q;
  logic            req_acc, rsp_acc;

  logic tok_vld [TABLE_DEPTH+1];
  tok_t tok     [TABLE_DEPTH+1];

  status_e           res_status;
  logic [CntW-1:0]   res_cnt;
  logic [LimW-1:0]   res_lim;
  logic [DelayW-1:0] res_delay;

  logic              rsp_vld_q;
  status_e           rsp_status_q;
  logic [CntW-1:0]   rsp_cnt_q;
  logic [LimW-1:0]   rsp_lim_q;
  logic [DelayW-1:0] rsp_delay_q;

  assign req_i.ready = !busy_q;
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_acc     = rsp_vld_q && rsp_o.ready;

  always_comb begin
    tok_vld[0]      = req_acc;
    tok[0].cmd      = cmd_e'(req_i.command);
    tok[0].key      = req_i.job_key;
    tok[0].lim      = req_i.retry_limit;
    tok[0].base     = req_i.base_delay;
    tok[0].cnt      = '0;
    tok[0].found    = 1'b0;
    tok[0].appended = 1'b0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rbt_cell #(
      .CellIdx (i),
      .IdxW    (IdxW),
      .SlotKeyW(SlotKeyW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .used_i   (used_q),
      .tok_vld_i(tok_vld[i]),
      .tok_i    (tok[i]),
      .tok_vld_o(tok_vld[i+1]),
      .tok_o    (tok[i+1])
    );
  end

  rbt_backoff u_backoff (
    .tok_i   (tok[TABLE_DEPTH]),
    .status_o(res_status),
    .cnt_o   (res_cnt),
    .lim_o   (res_lim),
    .delay_o (res_delay)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      used_q    <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_acc) begin
        busy_q <= 1'b1;
      end else if (rsp_acc) begin
        busy_q <= 1'b0;
      end
      if (tok_vld[TABLE_DEPTH] && tok[TABLE_DEPTH].appended) begin
        used_q <= used_q + 1'b1;
      end
      if (tok_vld[TABLE_DEPTH]) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_acc) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_vld[TABLE_DEPTH]) begin
      rsp_status_q <= res_status;
      rsp_cnt_q    <= res_cnt;
      rsp_lim_q    <= res_lim;
      rsp_delay_q  <= res_delay;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.retry_count   = rsp_cnt_q;
  assign rsp_o.limit_out     = rsp_lim_q;
  assign rsp_o.delay_seconds = rsp_delay_q;

  `RBT_ASSERT_NEXT(a_one_in_flight, req_acc, !req_i.ready, "second word taken while busy")
  `RBT_ASSERT_NOW(a_used_bound, 1'b1, used_q <= DepthVal, "slot count beyond table depth")
  `RBT_ASSERT_NOW(a_chain_idle, rsp_vld_q, !tok_vld[TABLE_DEPTH], "chain word while response waits")
  `RBT_ASSERT_NOW(a_delay_ok_only, rsp_vld_q && rsp_status_q != ST_OK, rsp_delay_q == '0, "delay on a failed command")

endmodule

`default_nettype wire
